>>> rtl/psfp_pkg.sv
// Package for the particulate sensor frame parser.
// Holds frame constants, result status codes and the store write-port type.
// No dependencies; used by psfp_store and particle_sensor_frame_parser.
package psfp_pkg;

  // Frame layout
  localparam logic [7:0] Hdr0Byte  = 8'h42;
  localparam logic [7:0] Hdr1Byte  = 8'h4D;
  localparam logic [7:0] Len0Byte  = 8'h00;
  localparam logic [7:0] Len1Byte  = 8'h1C;
  localparam int unsigned NumWords = 12;
  localparam int unsigned SlotW    = $clog2(NumWords);

  // Byte positions inside the frame
  localparam logic [4:0] PosFirstWord = 5'd5;   // low byte of word 0
  localparam logic [4:0] PosLastWord  = 5'd27;  // low byte of word 11
  localparam logic [4:0] PosCkLow     = 5'd31;  // low byte of checksum

  // Result status codes
  localparam logic [1:0] StatusValue  = 2'd0;
  localparam logic [1:0] StatusCkErr  = 2'd1;
  localparam logic [1:0] StatusHdrErr = 2'd2;

  // Write port of the measurement store
  typedef struct packed {
    logic             en;
    logic [SlotW-1:0] addr;
    logic [15:0]      data;
  } wr_t;

  // Expected byte at header/length positions 0..3
  function automatic logic [7:0] expect_byte(input logic [1:0] pos);
    logic [7:0] b;
    unique case (pos)
      2'd0:    b = Hdr0Byte;
      2'd1:    b = Hdr1Byte;
      2'd2:    b = Len0Byte;
      default: b = Len1Byte;
    endcase
    return b;
  endfunction

endpackage

>>> rtl/particle_sensor_frame_parser.sv
// Particulate sensor frame parser: one input byte per cycle, no result mid-frame.
// Output: an error beat shows the cycle after its byte is taken; a good frame's values
// pass the dump flag, store read register and output register, one slot a cycle
// while the output is not stalled. Stalls: a result-producing byte waits out a dump or a
// stalled beat; a byte that would overwrite an unread slot waits for its read.
// Reset clears position, sum, hold byte and all valid flags; the store is not cleared.
module particle_sensor_frame_parser (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  rx_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  status_o,
  output logic [3:0]  word_index_o,
  output logic [15:0] word_value_o,
  output logic        last_o
);

  localparam int unsigned SlotW = psfp_pkg::SlotW;
  localparam logic [SlotW-1:0] LastSlot = SlotW'(psfp_pkg::NumWords - 1);

  logic [4:0]       pos_q, pos_d;
  logic [15:0]      sum_q, sum_d;
  logic [7:0]       hold_q, hold_d;
  logic             dump_q, dump_d;
  logic [SlotW-1:0] rd_ptr_q, rd_ptr_d;

  logic             out_valid_q, out_valid_d;
  logic [1:0]       status_q, status_d;
  logic [3:0]       idx_q, idx_d;
  logic [15:0]      val_q, val_d;
  logic             last_q, last_d;

  logic             in_fire, out_ready;
  logic             hdr_bad, is_ck, is_wr, ck_ok, gen_res, busy, conflict;
  logic [SlotW-1:0] wr_slot;
  logic             issue, s1_take, err_load;
  psfp_pkg::wr_t    wr;
  logic             rd_valid;
  logic [SlotW-1:0] rd_idx;
  logic [15:0]      rd_data;

  // Decode the current byte position
  assign hdr_bad = (pos_q < 5'd4) && (rx_byte_i != psfp_pkg::expect_byte(pos_q[1:0]));
  assign is_ck   = (pos_q == psfp_pkg::PosCkLow);
  assign is_wr   = (pos_q >= psfp_pkg::PosFirstWord) && (pos_q <= psfp_pkg::PosLastWord)
                   && pos_q[0];
  assign wr_slot = SlotW'(pos_q[4:1] - 4'd2);
  assign ck_ok   = ({hold_q, rx_byte_i} == sum_q);
  assign gen_res = hdr_bad || is_ck;

  // Output handshake and dump pipeline
  assign out_ready = !out_valid_q || !out_stall_i;
  assign busy      = dump_q || rd_valid;
  assign s1_take   = rd_valid && out_ready;
  assign issue     = dump_q && (!rd_valid || s1_take);

  // Hold a byte that must wait for the dump or a stalled beat, or would clobber an unread slot
  assign conflict   = dump_q && is_wr && (wr_slot >= rd_ptr_q);
  assign in_stall_o = (gen_res && (busy || !out_ready)) || conflict;
  assign in_fire    = in_valid_i && !in_stall_o;
  assign err_load   = in_fire && (hdr_bad || (is_ck && !ck_ok));

  // Store write port
  assign wr.en   = in_fire && is_wr;
  assign wr.addr = wr_slot;
  assign wr.data = {hold_q, rx_byte_i};

  psfp_store u_store (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_i       (wr),
    .rd_en_i    (issue),
    .rd_addr_i  (rd_ptr_q),
    .rd_take_i  (s1_take),
    .rd_valid_o (rd_valid),
    .rd_idx_o   (rd_idx),
    .rd_data_o  (rd_data)
  );

  // Advance the frame parser
  always_comb begin
    pos_d    = pos_q;
    sum_d    = sum_q;
    hold_d   = hold_q;
    dump_d   = dump_q;
    rd_ptr_d = rd_ptr_q;
    if (issue) begin
      rd_ptr_d = rd_ptr_q + 1'b1;
      if (rd_ptr_q == LastSlot) begin
        dump_d = 1'b0;
      end
    end
    if (in_fire) begin
      if (hdr_bad) begin
        pos_d  = '0;
        sum_d  = '0;
        hold_d = '0;
      end else if (is_ck) begin
        pos_d  = '0;
        sum_d  = '0;
        hold_d = '0;
        if (ck_ok) begin
          dump_d   = 1'b1;
          rd_ptr_d = '0;
        end
      end else begin
        pos_d = pos_q + 5'd1;
        if (pos_q < 5'd30) begin
          sum_d = sum_q + 16'(rx_byte_i);
        end
        if ((pos_q >= 5'd4) && !pos_q[0] && (pos_q != 5'd28)) begin
          hold_d = rx_byte_i;
        end
      end
    end
  end

  // Load the output register
  always_comb begin
    out_valid_d = out_valid_q;
    status_d    = status_q;
    idx_d       = idx_q;
    val_d       = val_q;
    last_d      = last_q;
    if (out_ready) begin
      out_valid_d = s1_take || err_load;
      if (s1_take) begin
        status_d = psfp_pkg::StatusValue;
        idx_d    = 4'(rd_idx);
        val_d    = rd_data;
        last_d   = (rd_idx == LastSlot);
      end else if (err_load) begin
        status_d = hdr_bad ? psfp_pkg::StatusHdrErr : psfp_pkg::StatusCkErr;
        idx_d    = '0;
        val_d    = '0;
        last_d   = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= '0;
      sum_q       <= '0;
      hold_q      <= '0;
      dump_q      <= 1'b0;
      rd_ptr_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      pos_q       <= pos_d;
      sum_q       <= sum_d;
      hold_q      <= hold_d;
      dump_q      <= dump_d;
      rd_ptr_q    <= rd_ptr_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    status_q <= status_d;
    idx_q    <= idx_d;
    val_q    <= val_d;
    last_q   <= last_d;
  end

  assign out_valid_o  = out_valid_q;
  assign status_o     = status_q;
  assign word_index_o = idx_q;
  assign word_value_o = val_q;
  assign last_o       = last_q;

endmodule

>>> rtl/psfp_store.sv
// Measurement store: 12 x 16-bit synchronous memory with a registered read.
// Also holds the read-data stage (valid, slot index, data) for the dump.
// Depends on psfp_pkg.
module psfp_store (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  psfp_pkg::wr_t                wr_i,
  input  logic                         rd_en_i,
  input  logic [psfp_pkg::SlotW-1:0]   rd_addr_i,
  input  logic                         rd_take_i,
  output logic                         rd_valid_o,
  output logic [psfp_pkg::SlotW-1:0]   rd_idx_o,
  output logic [15:0]                  rd_data_o
);

  logic [15:0]                mem_q [psfp_pkg::NumWords];
  logic [15:0]                rdata_q;
  logic [psfp_pkg::SlotW-1:0] ridx_q;
  logic                       rvalid_q, rvalid_d;

  // Write one word per accepted low byte
  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[wr_i.addr] <= wr_i.data;
    end
  end

  // Read data register: loads on issue, holds otherwise
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rdata_q <= mem_q[rd_addr_i];
      ridx_q  <= rd_addr_i;
    end
  end

  // Track whether the read stage holds a beat
  always_comb begin
    rvalid_d = rvalid_q;
    if (rd_en_i) begin
      rvalid_d = 1'b1;
    end else if (rd_take_i) begin
      rvalid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rvalid_q <= 1'b0;
    end else begin
      rvalid_q <= rvalid_d;
    end
  end

  assign rd_valid_o = rvalid_q;
  assign rd_idx_o   = ridx_q;
  assign rd_data_o  = rdata_q;

endmodule

>>> rtl/psfp_checker.sv
// Port-level checker for the particulate sensor frame parser, bound to the top.
// Depends on psfp_pkg and particle_sensor_frame_parser.
module psfp_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [1:0]  status_o,
  input logic [3:0]  word_index_o,
  input logic [15:0] word_value_o,
  input logic        last_o
);

  // A stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(status_o)
      && $stable(word_index_o) && $stable(word_value_o) && $stable(last_o))
    else $error("stalled result beat changed");

  // Only defined status codes appear
  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (status_o == psfp_pkg::StatusValue)
      || (status_o == psfp_pkg::StatusCkErr) || (status_o == psfp_pkg::StatusHdrErr))
    else $error("undefined status code");

  // Error beats are marked last, with zero index and value
  a_err_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != psfp_pkg::StatusValue)
      |-> last_o && (word_index_o == 4'd0) && (word_value_o == 16'd0))
    else $error("malformed error beat");

  // A value beat is last exactly on slot 11
  a_value_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == psfp_pkg::StatusValue)
      |-> (last_o == (word_index_o == 4'd11)) && (word_index_o <= 4'd11))
    else $error("value beat last flag or slot wrong");

endmodule

bind particle_sensor_frame_parser psfp_checker u_psfp_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .status_o     (status_o),
  .word_index_o (word_index_o),
  .word_value_o (word_value_o),
  .last_o       (last_o)
);

>>> dv/particle_sensor_frame_parser_tb.sv
// Testbench for particle_sensor_frame_parser: byte stream driver, result monitor and predictor.
// Depends on rtl/psfp_pkg.sv for frame bytes, word count and status codes.
module particle_sensor_frame_parser_tb;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned StallLimit = 4000;
  localparam int unsigned PhaseItems = 80;
  localparam logic [31:0] HeaderSeq  = {psfp_pkg::Len1Byte, psfp_pkg::Len0Byte,
                                        psfp_pkg::Hdr1Byte, psfp_pkg::Hdr0Byte};

  typedef struct packed {
    logic [1:0]  status;
    logic [3:0]  index;
    logic [15:0] value;
    logic        last;
  } frame_out_t;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic        in_stall_o;
  logic [7:0]  rx_byte_i   = 8'h00;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [1:0]  status_o;
  logic [3:0]  word_index_o;
  logic [15:0] word_value_o;
  logic        last_o;

  particle_sensor_frame_parser dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .rx_byte_i    (rx_byte_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .status_o     (status_o),
    .word_index_o (word_index_o),
    .word_value_o (word_value_o),
    .last_o       (last_o)
  );

  // Stimulus and prediction state
  logic [7:0]  byte_backlog[$];
  frame_out_t  predicted_out[$];
  logic [7:0]  frame_buf [32];
  int unsigned queued_count   = 0;
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned error_count    = 0;
  int unsigned result_seq     = 0;
  int unsigned idle_cycles    = 0;

  // Shadow copy of the parser state
  logic [4:0]  frame_pos;
  logic [15:0] frame_sum;
  logic [7:0]  high_byte;
  logic [15:0] word_store [psfp_pkg::NumWords];

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  task automatic report_error(input string msg);
    if (error_count < 100) $display("ERROR @%0t: %s", $time, msg);
    error_count++;
  endtask

  task automatic check_field(input string name, input int got, input int want);
    if (got != want) begin
      report_error($sformatf("result %0d: %s got %0h, want %0h", result_seq, name, got, want));
    end
  endtask

  // Advance the shadow parser by one byte and queue the results it yields
  task automatic parse_frame_byte(input logic [7:0] b);
    logic [15:0] rx_sum;
    frame_out_t  item;
    int          k;
    if (frame_pos < 5'd4) begin
      if (b != HeaderSeq[frame_pos[1:0]*8 +: 8]) begin
        frame_pos = '0;
        frame_sum = '0;
        high_byte = '0;
        item = '{status: psfp_pkg::StatusHdrErr, index: 4'd0, value: 16'd0, last: 1'b1};
        predicted_out.push_back(item);
      end else begin
        frame_sum = frame_sum + 16'(b);
        frame_pos = frame_pos + 5'd1;
      end
    end else if (frame_pos < 5'd30) begin
      frame_sum = frame_sum + 16'(b);
      if (frame_pos < 5'd28) begin
        if (!frame_pos[0]) begin
          high_byte = b;
        end else begin
          word_store[(frame_pos - 5'd4) >> 1] = {high_byte, b};
        end
      end
      frame_pos = frame_pos + 5'd1;
    end else if (frame_pos == 5'd30) begin
      high_byte = b;
      frame_pos = 5'd31;
    end else begin
      // trailing checksum: report the frame or a single mismatch
      rx_sum = {high_byte, b};
      if (rx_sum != frame_sum) begin
        item = '{status: psfp_pkg::StatusCkErr, index: 4'd0, value: 16'd0, last: 1'b1};
        predicted_out.push_back(item);
      end else begin
        for (k = 0; k < psfp_pkg::NumWords; k++) begin
          item = '{status: psfp_pkg::StatusValue, index: 4'(k), value: word_store[k],
                   last: (k == psfp_pkg::NumWords - 1)};
          predicted_out.push_back(item);
        end
      end
      frame_pos = '0;
      frame_sum = '0;
      high_byte = '0;
    end
  endtask

  function automatic logic [7:0] rand_byte();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 10) return 8'h00;
    if (roll < 20) return 8'hFF;
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic push_byte(input logic [7:0] b);
    byte_backlog.push_back(b);
    queued_count++;
  endtask

  // Build a well-formed frame in frame_buf; extreme words alternate 0x0000 and 0xFFFF
  task automatic fill_frame(input bit extremes, input logic [7:0] ver, input logic [7:0] err);
    logic [15:0] sum;
    int          i;
    frame_buf[0] = psfp_pkg::Hdr0Byte;
    frame_buf[1] = psfp_pkg::Hdr1Byte;
    frame_buf[2] = psfp_pkg::Len0Byte;
    frame_buf[3] = psfp_pkg::Len1Byte;
    for (i = 4; i < 28; i++) begin
      if (extremes) frame_buf[i] = (((i - 4) >> 1) & 1) ? 8'hFF : 8'h00;
      else frame_buf[i] = rand_byte();
    end
    frame_buf[28] = ver;
    frame_buf[29] = err;
    sum = '0;
    for (i = 0; i < 30; i++) sum = sum + 16'(frame_buf[i]);
    frame_buf[30] = sum[15:8];
    frame_buf[31] = sum[7:0];
  endtask

  task automatic push_frame(input int unsigned count);
    int unsigned i;
    for (i = 0; i < count; i++) push_byte(frame_buf[i]);
  endtask

  // Send the first keep header bytes correctly, then one wrong byte
  task automatic push_header_break(input int unsigned keep, input logic [7:0] wrong);
    int unsigned i;
    for (i = 0; i < keep; i++) push_byte(HeaderSeq[i*8 +: 8]);
    push_byte(wrong);
  endtask

  task automatic push_random_sequence();
    int unsigned roll;
    int unsigned keep;
    int unsigned cut;
    int unsigned i;
    logic [15:0] flip;
    logic [7:0]  b;
    roll = $urandom_range(0, 99);
    if (roll < 60) begin
      fill_frame(1'b0, rand_byte(), rand_byte());
      push_frame(32);
    end else if (roll < 75) begin
      // corrupt the checksum
      fill_frame(1'b0, rand_byte(), rand_byte());
      flip = 16'($urandom_range(1, 16'hFFFF));
      frame_buf[30] = frame_buf[30] ^ flip[15:8];
      frame_buf[31] = frame_buf[31] ^ flip[7:0];
      push_frame(32);
    end else if (roll < 85) begin
      keep = $urandom_range(0, 3);
      b = 8'($urandom_range(0, 255));
      if (b == HeaderSeq[keep*8 +: 8]) b = ~b;
      push_header_break(keep, b);
    end else if (roll < 92) begin
      // noise that never looks like a frame start
      cut = $urandom_range(1, 6);
      for (i = 0; i < cut; i++) begin
        b = rand_byte();
        if (b == psfp_pkg::Hdr0Byte) b = ~b;
        push_byte(b);
      end
    end else begin
      // truncated frame, padded with junk so the stream realigns
      fill_frame(1'b0, rand_byte(), rand_byte());
      cut = $urandom_range(5, 31);
      push_frame(cut);
      for (i = cut; i < 32; i++) push_byte(rand_byte());
    end
  endtask

  task automatic push_directed();
    // header or length mismatch at each position
    push_header_break(0, 8'hFF);
    push_header_break(1, 8'h00);
    push_header_break(2, 8'hFF);
    push_header_break(3, 8'h1D);
    // a repeated first header byte is a header error, not taken as a new start
    push_byte(psfp_pkg::Hdr0Byte);
    push_byte(psfp_pkg::Hdr0Byte);
    // good frame with extreme words, then a checksum off by one
    fill_frame(1'b1, 8'hFF, 8'h00);
    push_frame(32);
    fill_frame(1'b0, 8'h00, 8'hFF);
    frame_buf[31] = frame_buf[31] ^ 8'h01;
    push_frame(32);
  endtask

  // Driver: present backlog bytes, hold a stalled beat
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      rx_byte_i  <= 8'h00;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        parse_frame_byte(byte_backlog[0]);
        void'(byte_backlog.pop_front());
      end
      if (!(in_valid_i && in_stall_o)) begin
        if (byte_backlog.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          in_valid_i <= 1'b1;
          rx_byte_i  <= byte_backlog[0];
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each accepted result beat with the oldest prediction
  always @(posedge clk_i or negedge rst_ni) begin : monitor
    frame_out_t want;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (predicted_out.size() == 0) begin
          report_error($sformatf("result %0d: unexpected status=%0d index=%0d value=%0h",
                                 result_seq, status_o, word_index_o, word_value_o));
        end else begin
          want = predicted_out.pop_front();
          check_field("status", status_o, want.status);
          check_field("word_index", word_index_o, want.index);
          check_field("word_value", word_value_o, want.value);
          check_field("last", last_o, want.last);
        end
        result_seq++;
      end
      out_stall_i <= ($urandom_range(0, 99) < recv_stall_pct);
    end
  end

  // Watchdog: end the run when nothing moves for too long
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= StallLimit) begin
      $display("Verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Sequence: reset, then four phases with different sender idle and receiver stall rates, each drained before the next
  initial begin : stimulus
    int unsigned phase;
    int unsigned target;
    frame_pos = '0;
    frame_sum = '0;
    high_byte = '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    for (phase = 0; phase < 4; phase++) begin
      @(negedge clk_i);
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 80; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 80; end
        default: begin send_idle_pct = 17; recv_stall_pct = 17; end
      endcase
      if (phase == 0) push_directed();
      target = queued_count + PhaseItems;
      while (queued_count < target) push_random_sequence();
      // wait until every byte is sent and every predicted result has come
      while (byte_backlog.size() != 0 || predicted_out.size() != 0 || in_valid_i) begin
        @(negedge clk_i);
      end
      repeat (4) @(negedge clk_i);
    end
    repeat (20) @(negedge clk_i);
    if (predicted_out.size() != 0) begin
      report_error($sformatf("%0d predicted results never arrived", predicted_out.size()));
    end
    if (error_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
